### rtl/cnms_pkg.sv
`default_nettype none
package cnms_pkg;

  // Sizing of the block
  localparam int MAX_SLICES = 512;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = 24;
  localparam int ADDR_W     = $clog2(MAX_SLICES);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int ROW_DEPTH  = MAX_SLICES / 3 + 1;
  localparam int NUM_CELLS  = ROW_DEPTH - 1;
  localparam int PICK_W     = $clog2(ROW_DEPTH);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic clr;    // zero both rows
    logic step;   // fold one element into the rows
    logic shift;  // move the current row one cell toward cell 0
  } cnms_ctrl_t;

endpackage
`default_nettype wire

### rtl/cnms_ram.sv
`default_nettype none
module cnms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/cnms_cell.sv
`default_nettype none
module cnms_cell (
  input  wire logic                        clk,
  input  wire cnms_pkg::cnms_ctrl_t        ctrl,
  input  wire logic [cnms_pkg::VAL_W-1:0]  v,
  input  wire logic [cnms_pkg::SUM_W-1:0]  two_in,
  input  wire logic [cnms_pkg::SUM_W-1:0]  one_in,
  output logic      [cnms_pkg::SUM_W-1:0]  two_out,
  output logic      [cnms_pkg::SUM_W-1:0]  one_out
);
  import cnms_pkg::*;

  logic [SUM_W-1:0] one;
  logic [SUM_W-1:0] two;
  logic [SUM_W:0]   take_raw;
  logic [SUM_W-1:0] take;
  logic [SUM_W-1:0] one_next;

  // take = v + best with one pick fewer two elements ahead (saturating)
  assign take_raw = {1'b0, two_in} + (SUM_W + 1)'(v);
  assign take     = take_raw[SUM_W] ? SUM_MAX : take_raw[SUM_W-1:0];
  assign one_next = (take > one) ? take : one;

  // Rolling rows for this pick count
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      one <= '0;
      two <= '0;
    end else if (ctrl.step) begin
      two <= one;
      one <= one_next;
    end else if (ctrl.shift) begin
      one <= one_in;
    end
  end

  assign two_out = two;
  assign one_out = one;

endmodule
`default_nettype wire

### rtl/circular_nonadjacent_max_sum_top.sv
// Channel  | Handshake                   | Payload
// slice    | slice_valid / slice_stall   | slice_value[15:0], last
// result   | result_valid / result_stall | best_sum[23:0], overflow
//
// Elements load one per cycle. After the last one the row of cells runs two
// passes, each one element per cycle from the value RAM read port, then shifts
// the row picks-1 cells toward cell 0, where the result of each pass is read.
// slice_stall stays high from the last element until the result transfer.
// rst is synchronous and clears counters and the sequencer; RAM keeps data.
`default_nettype none
module circular_nonadjacent_max_sum_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       slice_valid,
  output logic                            slice_stall,
  input  wire logic [cnms_pkg::VAL_W-1:0] slice_value,
  input  wire logic                       last,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic      [cnms_pkg::SUM_W-1:0] best_sum,
  output logic                            overflow
);
  import cnms_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [1:0]        mod3;
  logic [PICK_W-1:0] picks_cnt;
  logic [PICK_W-1:0] picks;
  logic [PICK_W-1:0] sh;
  logic              ovf;
  logic              pass;
  logic              rd_vld;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] k_m1;
  logic [SUM_W-1:0]  first_best;

  logic              acc;
  logic              room;
  logic [PICK_W-1:0] picks_now;
  logic [CNT_W-1:0]  k_now;
  logic [VAL_W-1:0]  rd_val;
  cnms_ctrl_t        ctrl;

  logic [SUM_W-1:0]  one_w [NUM_CELLS];
  logic [SUM_W-1:0]  two_w [NUM_CELLS];

  // Load side bookkeeping
  assign slice_stall  = (state != S_LOAD);
  assign result_valid = (state == S_OUT);
  assign acc          = slice_valid && !slice_stall;
  assign room         = (count < CNT_W'(MAX_SLICES));
  assign picks_now    = picks_cnt + PICK_W'(room && (mod3 == 2'd2));
  assign k_now        = count + CNT_W'(room);

  // Cell row control
  always_comb begin
    ctrl.clr   = (acc && last && (picks_now != '0)) || ((state == S_NEXT) && !pass);
    ctrl.step  = rd_vld;
    ctrl.shift = (state == S_SHIFT) && (sh != '0);
  end

  cnms_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_SLICES)
  ) u_store (
    .clk  (clk),
    .we   (acc && room),
    .waddr(count[ADDR_W-1:0]),
    .wdata(slice_value),
    .re   (state == S_RUN),
    .raddr(idx),
    .rdata(rd_val)
  );

  // Row of cells, cell g holds pick count g+1
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    logic [SUM_W-1:0] two_in;
    logic [SUM_W-1:0] one_in;
    if (g == 0) begin : g_first
      assign two_in = '0;
    end else begin : g_mid
      assign two_in = two_w[g-1];
    end
    if (g == NUM_CELLS - 1) begin : g_end
      assign one_in = '0;
    end else begin : g_body
      assign one_in = one_w[g+1];
    end
    cnms_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .v      (rd_val),
      .two_in (two_in),
      .one_in (one_in),
      .two_out(two_w[g]),
      .one_out(one_w[g])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      mod3      <= '0;
      picks_cnt <= '0;
      ovf       <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= (state == S_RUN);
      case (state)
        S_LOAD: begin
          if (acc) begin
            if (last) begin
              // list ends here, the element itself was stored if there was room
              overflow  <= ovf || !room;
              count     <= '0;
              mod3      <= '0;
              picks_cnt <= '0;
              ovf       <= 1'b0;
              picks     <= picks_now;
              idx       <= ADDR_W'(k_now - CNT_W'(2));
              k_m1      <= ADDR_W'(k_now - CNT_W'(1));
              pass      <= 1'b0;
              if (picks_now == '0) begin
                best_sum <= '0;
                state    <= S_OUT;
              end else begin
                state <= S_RUN;
              end
            end else if (room) begin
              count <= count + 1'b1;
              if (mod3 == 2'd2) begin
                mod3      <= '0;
                picks_cnt <= picks_cnt + 1'b1;
              end else begin
                mod3 <= mod3 + 1'b1;
              end
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_RUN: begin
          if (idx == ADDR_W'(pass)) begin
            state <= S_WAIT;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_WAIT: begin
          sh    <= picks - 1'b1;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (sh == '0) begin
            state <= S_NEXT;
          end else begin
            sh <= sh - 1'b1;
          end
        end
        S_NEXT: begin
          if (!pass) begin
            first_best <= one_w[0];
            idx        <= k_m1;
            pass       <= 1'b1;
            state      <= S_RUN;
          end else begin
            best_sum <= (first_best > one_w[0]) ? first_best : one_w[0];
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_stall) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/cnms_checker.sv
`default_nettype none
module cnms_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       slice_valid,
  input wire logic                       slice_stall,
  input wire logic                       last,
  input wire logic                       result_valid,
  input wire logic                       result_stall,
  input wire logic [cnms_pkg::SUM_W-1:0] best_sum,
  input wire logic                       overflow
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(best_sum) && $stable(overflow))
    else $error("stalled result changed");

  // No element is taken while a result waits
  a_no_load_on_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> slice_stall)
    else $error("input open while result pending");

  // The list end closes the input until the result is out
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    slice_valid && !slice_stall && last |=> slice_stall)
    else $error("input open right after list end");

  // One result per list
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=> !result_valid)
    else $error("result repeated");

endmodule

bind circular_nonadjacent_max_sum_top cnms_checker u_cnms_checker (
  .clk         (clk),
  .rst         (rst),
  .slice_valid (slice_valid),
  .slice_stall (slice_stall),
  .last        (last),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .best_sum    (best_sum),
  .overflow    (overflow)
);
`default_nettype wire

### bench/testbench.sv
module testbench;
  import cnms_pkg::*;

  // One expected result: best sum and overflow flag
  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } pizza_result_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        slice_valid  = 1'b0;
  logic        slice_stall;
  logic [15:0] slice_value  = '0;
  logic        last         = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [23:0] best_sum;
  logic        overflow;

  circular_nonadjacent_max_sum_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .slice_valid  (slice_valid),
    .slice_stall  (slice_stall),
    .slice_value  (slice_value),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .best_sum     (best_sum),
    .overflow     (overflow)
  );

  always #10 clk = ~clk;

  // Predictor state: the list being loaded
  logic [VAL_W-1:0] list_vals [0:MAX_SLICES-1];
  int               list_len   = 0;
  bit               list_over  = 1'b0;
  pizza_result_t    expected_sums [$];

  int err_count  = 0;
  int items_sent = 0;
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  int hold_left  = 0;

  // Best sum of up to picks non-adjacent elements in list_vals[lo..hi]
  function automatic logic [SUM_W-1:0] chain_best(int lo, int hi, int picks);
    logic [SUM_W-1:0] two_back [0:ROW_DEPTH-1];
    logic [SUM_W-1:0] one_back [0:ROW_DEPTH-1];
    logic [SUM_W-1:0] row      [0:ROW_DEPTH-1];
    logic [SUM_W:0]   take;
    for (int n = 0; n < ROW_DEPTH; n++) begin
      two_back[n] = '0;
      one_back[n] = '0;
      row[n]      = '0;
    end
    if (picks > ROW_DEPTH - 1)
      picks = ROW_DEPTH - 1;
    // walk from the top of the range down, one element per row update
    for (int i = hi; i >= lo; i--) begin
      for (int n = 1; n <= picks; n++) begin
        take = list_vals[i] + two_back[n-1];
        if (take > SUM_MAX)
          take = SUM_MAX;
        row[n] = (take[SUM_W-1:0] > one_back[n]) ? take[SUM_W-1:0] : one_back[n];
      end
      two_back = one_back;
      one_back = row;
    end
    return one_back[picks];
  endfunction

  // Circle: drop the last element in one pass, the first in the other
  function automatic logic [SUM_W-1:0] circle_best(int k);
    int               picks;
    logic [SUM_W-1:0] without_last;
    logic [SUM_W-1:0] without_first;
    picks = k / 3;
    if (picks == 0)
      return '0;
    without_last  = chain_best(0, k - 2, picks);
    without_first = chain_best(1, k - 1, picks);
    return (without_last > without_first) ? without_last : without_first;
  endfunction

  // Fold one accepted element into the predictor
  task automatic absorb_slice(logic [15:0] v, logic l);
    pizza_result_t r;
    if (list_len < MAX_SLICES) begin
      list_vals[list_len] = v;
      list_len++;
    end else begin
      list_over = 1'b1;
    end
    if (l) begin
      r.sum = circle_best(list_len);
      r.ovf = list_over;
      expected_sums.push_back(r);
      list_len  = 0;
      list_over = 1'b0;
    end
  endtask

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10)
      $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!gaps_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [15:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one element and hold it until the transfer
  task automatic send_slice(logic [15:0] v, logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      slice_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    slice_valid <= 1'b1;
    slice_value <= v;
    last        <= l;
    @(posedge clk);
    while (slice_stall) @(posedge clk);
    items_sent++;
    absorb_slice(v, l);
  endtask

  task automatic send_list(int n);
    for (int i = 0; i < n; i++)
      send_slice(rand_value(), i == n - 1);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_drained();
    @(negedge clk);
    slice_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  // Receiver: forced hold-off, random bursts, or always ready
  initial begin : stall_driver
    int burst;
    int r;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (!stalls_on) begin
        result_stall <= 1'b0;
      end else if (burst > 0) begin
        result_stall <= 1'b1;
        burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          result_stall <= 1'b0;
        end else if (r < 95) begin
          result_stall <= 1'b1;
          burst = $urandom_range(0, 2);
        end else begin
          result_stall <= 1'b1;
          burst = $urandom_range(5, 40);
        end
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    pizza_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_sums.size() == 0) begin
        note_error($sformatf("unexpected result best_sum %0d overflow %0b",
                             best_sum, overflow));
      end else begin
        want = expected_sums.pop_front();
        if (best_sum !== want.sum)
          note_error($sformatf("best_sum expected %0d got %0d", want.sum, best_sum));
        if (overflow !== want.ovf)
          note_error($sformatf("overflow expected %0b got %0b", want.ovf, overflow));
      end
    end
  end

  // Lists too short to pick anything, and the smallest list that picks one
  task automatic test_short_lists();
    send_slice(16'hFFFF, 1'b1);
    send_slice(16'hFFFF, 1'b0);
    send_slice(16'hFFFF, 1'b1);
    send_slice(16'h0001, 1'b0);
    send_slice(16'hFFFF, 1'b0);
    send_slice(16'h0002, 1'b1);
    send_slice(16'h0000, 1'b0);
    send_slice(16'h0000, 1'b0);
    send_slice(16'h0000, 1'b1);
  endtask

  // Extreme values, and large values that are neighbors only across the wrap
  task automatic test_circle_extremes();
    for (int i = 0; i < 6; i++)
      send_slice((i % 2) ? 16'hFFFF : 16'h0000, i == 5);
    for (int i = 0; i < 6; i++)
      send_slice((i == 0 || i == 5) ? 16'hFFFF : 16'h0001, i == 5);
  endtask

  // Full list, overflowing list ending on a dropped element, then recovery
  task automatic test_overflow();
    send_list(MAX_SLICES);
    send_list(MAX_SLICES + 3);
    send_list(3);
  endtask

  // Receiver holds off while lists keep coming, so the input stalls
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    hold_left = 400;
    send_list(4);
    send_list(7);
    send_list(5);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // Back-to-back transfers on both sides
  task automatic test_no_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < 10; i++)
      send_list($urandom_range(1, 12));
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Random lists: mostly short, some medium, rarely near or past full
  task automatic test_random();
    int r;
    while (items_sent < 2000) begin
      r = $urandom_range(0, 99);
      if (r < 1)
        send_list($urandom_range(MAX_SLICES - 30, MAX_SLICES + 10));
      else if (r < 9)
        send_list($urandom_range(25, 170));
      else
        send_list($urandom_range(1, 24));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_short_lists();
    test_circle_extremes();
    test_overflow();
    test_backpressure();
    test_no_idle();
    test_random();
    wait_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #30000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
